### rtl/jse_pkg.sv
// Package for the JSON string escaper: opcodes, character codes,
// inter-stage word types and the hex digit helper. No dependencies.
`default_nettype none

package jse_pkg;

  // Input opcodes
  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_CHAR  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;
  localparam logic [1:0] OP_RSVD  = 2'd3;

  localparam int UNIT_W  = 16;
  localparam int MAX_OUT = 6;
  localparam int CNT_W   = 3;

  // Character codes
  localparam logic [UNIT_W-1:0] CH_QUOTE     = 16'h0022;
  localparam logic [UNIT_W-1:0] CH_BACKSLASH = 16'h005C;
  localparam logic [UNIT_W-1:0] CH_SPACE     = 16'h0020;
  localparam logic [UNIT_W-1:0] CH_ZERO      = 16'h0030;
  localparam logic [UNIT_W-1:0] CH_LA_M10    = 16'h0057; // 'a' - 10
  localparam logic [UNIT_W-1:0] CH_B         = 16'h0062;
  localparam logic [UNIT_W-1:0] CH_F         = 16'h0066;
  localparam logic [UNIT_W-1:0] CH_N         = 16'h006E;
  localparam logic [UNIT_W-1:0] CH_R         = 16'h0072;
  localparam logic [UNIT_W-1:0] CH_T         = 16'h0074;
  localparam logic [UNIT_W-1:0] CH_U         = 16'h0075;

  // Control codes with short escapes
  localparam logic [UNIT_W-1:0] CC_BS  = 16'h0008;
  localparam logic [UNIT_W-1:0] CC_TAB = 16'h0009;
  localparam logic [UNIT_W-1:0] CC_LF  = 16'h000A;
  localparam logic [UNIT_W-1:0] CC_FF  = 16'h000C;
  localparam logic [UNIT_W-1:0] CC_CR  = 16'h000D;

  // Escape counts
  localparam logic [CNT_W-1:0] CNT_ONE  = 3'd1;
  localparam logic [CNT_W-1:0] CNT_PAIR = 3'd2;
  localparam logic [CNT_W-1:0] CNT_HEX  = 3'd6;

  typedef enum logic [1:0] {
    CLS_QUOTE,
    CLS_PAIR,
    CLS_HEX,
    CLS_PLAIN
  } cls_t;

  // Classify -> expand word
  typedef struct packed {
    cls_t              cls;
    logic [UNIT_W-1:0] unit;
    logic [UNIT_W-1:0] second;
  } cls_word_t;

  // Expand -> serializer word
  typedef struct packed {
    logic [MAX_OUT-1:0][UNIT_W-1:0] units;
    logic [CNT_W-1:0]               cnt;
  } exp_word_t;

  // Lowercase hex digit as a code unit
  function automatic logic [UNIT_W-1:0] hex_digit(input logic [3:0] n);
    logic [UNIT_W-1:0] base;
    base = (n < 4'd10) ? CH_ZERO : CH_LA_M10;
    return base + UNIT_W'(n);
  endfunction

endpackage

`default_nettype wire

### rtl/jse_if.sv
// Channel interfaces of the JSON string escaper: input words and result words.
// Depends on nothing.
`default_nettype none

interface jse_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] code_unit;

  modport source (output valid, output opcode, output code_unit, input ready);
  modport sink   (input valid, input opcode, input code_unit, output ready);
endinterface

interface jse_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_unit;
  logic        last;

  modport source (output valid, output out_unit, output last, input ready);
  modport sink   (input valid, input out_unit, input last, output ready);
endinterface

`default_nettype wire

### rtl/json_string_escaper.sv
// Top level of the JSON string escaper: classify, expand and serialize stages.
// Depends on jse_pkg, jse_if, jse_classify, jse_expand and jse_serial.
//
//   channel  dir  payload                         handshake
//   in_ch    in   opcode[1:0], code_unit[15:0]    valid/ready
//   out_ch   out  out_unit[15:0], last            valid/ready
//
// An accepted word passes the classify and expand registers, the serializer
// buffer and the output register before its first output unit can be accepted.
// Quote and plain words leave at one per cycle while out_ch is ready; a two-unit
// or hex escape holds the serializer until its last unit is emitted, which sets the rate.
// Reset (synchronous, active low) clears only the stage valid bits and index.
// A stall on out_ch backs up through each stage's ready; nothing is dropped.
`default_nettype none

module json_string_escaper (
  input  wire logic clk,
  input  wire logic rst_n,
  jse_in_if.sink    in_ch,
  jse_out_if.source out_ch
);
  import jse_pkg::*;

  logic             cls_valid;
  logic             cls_ready;
  cls_word_t        cls_word;
  logic             exp_valid;
  logic             exp_ready;
  exp_word_t        exp_word;
  logic             buf_valid;
  logic [CNT_W-1:0] buf_idx;
  logic [CNT_W-1:0] buf_cnt;

  jse_classify u_classify (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .dn_valid (cls_valid),
    .dn_ready (cls_ready),
    .dn_word  (cls_word)
  );

  jse_expand u_expand (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (cls_valid),
    .up_ready (cls_ready),
    .up_word  (cls_word),
    .dn_valid (exp_valid),
    .dn_ready (exp_ready),
    .dn_word  (exp_word)
  );

  jse_serial u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (exp_valid),
    .up_ready  (exp_ready),
    .up_word   (exp_word),
    .out_ch    (out_ch),
    .buf_valid (buf_valid),
    .buf_idx   (buf_idx),
    .buf_cnt   (buf_cnt)
  );

  // Serializer index stays inside the held word
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    buf_valid |-> (buf_idx < buf_cnt))
    else $error("serializer index past unit count");

  // Expanded words only have the three legal lengths
  a_cnt_legal: assert property (@(posedge clk) disable iff (!rst_n)
    exp_valid |-> (exp_word.cnt == CNT_ONE || exp_word.cnt == CNT_PAIR ||
                   exp_word.cnt == CNT_HEX))
    else $error("illegal escape length");

  // An escape sequence goes out without gaps once started
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last) |=> out_ch.valid)
    else $error("gap inside escape sequence");

endmodule

`default_nettype wire

### rtl/jse_classify.sv
// Stage 1: sorts each input word into quote, two-unit escape, hex escape or
// plain pass-through. Depends on jse_pkg and jse_in_if.
`default_nettype none

module jse_classify (
  input  wire logic              clk,
  input  wire logic              rst_n,
  jse_in_if.sink                 in_ch,
  output logic                   dn_valid,
  input  wire logic              dn_ready,
  output jse_pkg::cls_word_t     dn_word
);
  import jse_pkg::*;

  logic      valid_r;
  cls_word_t word_r;
  cls_word_t word_nxt;
  logic      load;

  assign load        = !valid_r || dn_ready;
  assign in_ch.ready = load;
  assign dn_valid    = valid_r;
  assign dn_word     = word_r;

  // Classification of the incoming word
  always_comb begin
    word_nxt.unit   = in_ch.code_unit;
    word_nxt.second = in_ch.code_unit;
    word_nxt.cls    = CLS_PLAIN;
    if (in_ch.opcode != OP_CHAR) begin
      word_nxt.cls = CLS_QUOTE;
    end else begin
      unique case (in_ch.code_unit)
        CH_QUOTE, CH_BACKSLASH: word_nxt.cls = CLS_PAIR;
        CC_BS:  begin word_nxt.cls = CLS_PAIR; word_nxt.second = CH_B; end
        CC_FF:  begin word_nxt.cls = CLS_PAIR; word_nxt.second = CH_F; end
        CC_LF:  begin word_nxt.cls = CLS_PAIR; word_nxt.second = CH_N; end
        CC_CR:  begin word_nxt.cls = CLS_PAIR; word_nxt.second = CH_R; end
        CC_TAB: begin word_nxt.cls = CLS_PAIR; word_nxt.second = CH_T; end
        default: begin
          word_nxt.cls = (in_ch.code_unit < CH_SPACE) ? CLS_HEX : CLS_PLAIN;
        end
      endcase
    end
  end

  // Stage valid; the reserved opcode is dropped here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= in_ch.valid && (in_ch.opcode != OP_RSVD);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= word_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/jse_expand.sv
// Stage 2: expands a classified word into its list of output units and count.
// Depends on jse_pkg.
`default_nettype none

module jse_expand (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              up_valid,
  output logic                   up_ready,
  input  wire jse_pkg::cls_word_t up_word,
  output logic                   dn_valid,
  input  wire logic              dn_ready,
  output jse_pkg::exp_word_t     dn_word
);
  import jse_pkg::*;

  logic      valid_r;
  exp_word_t word_r;
  exp_word_t word_nxt;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_word  = word_r;

  // Unit list per class
  always_comb begin
    word_nxt.units = '0;
    word_nxt.cnt   = CNT_ONE;
    unique case (up_word.cls)
      CLS_QUOTE: begin
        word_nxt.units[0] = CH_QUOTE;
      end
      CLS_PAIR: begin
        word_nxt.units[0] = CH_BACKSLASH;
        word_nxt.units[1] = up_word.second;
        word_nxt.cnt      = CNT_PAIR;
      end
      CLS_HEX: begin
        word_nxt.units[0] = CH_BACKSLASH;
        word_nxt.units[1] = CH_U;
        word_nxt.units[2] = CH_ZERO;
        word_nxt.units[3] = CH_ZERO;
        word_nxt.units[4] = hex_digit({3'b000, up_word.unit[4]});
        word_nxt.units[5] = hex_digit(up_word.unit[3:0]);
        word_nxt.cnt      = CNT_HEX;
      end
      CLS_PLAIN: begin
        word_nxt.units[0] = up_word.unit;
      end
      default: begin
        word_nxt.units[0] = up_word.unit;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      word_r <= word_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/jse_serial.sv
// Stage 3: holds one expanded word and emits its units into the output register,
// one per cycle while it is free. Depends on jse_pkg and jse_out_if.
`default_nettype none

module jse_serial (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              up_valid,
  output logic                   up_ready,
  input  wire jse_pkg::exp_word_t up_word,
  jse_out_if.source              out_ch,
  output logic                   buf_valid,
  output logic [jse_pkg::CNT_W-1:0] buf_idx,
  output logic [jse_pkg::CNT_W-1:0] buf_cnt
);
  import jse_pkg::*;

  logic                  buf_valid_r;
  exp_word_t             buf_r;
  logic [CNT_W-1:0]      idx_r;
  logic                  out_valid_r;
  logic [UNIT_W-1:0]     out_unit_r;
  logic                  out_last_r;
  logic                  out_free;
  logic                  emit;
  logic                  buf_last;

  assign out_free = !out_valid_r || out_ch.ready;
  assign emit     = buf_valid_r && out_free;
  assign buf_last = (idx_r == (buf_r.cnt - CNT_ONE));
  assign up_ready = !buf_valid_r || (emit && buf_last);

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_unit = out_unit_r;
  assign out_ch.last     = out_last_r;
  assign buf_valid       = buf_valid_r;
  assign buf_idx         = idx_r;
  assign buf_cnt         = buf_r.cnt;

  // Control: buffer valid, unit index, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_r <= buf_valid_r;
      end
      if (up_ready) begin
        buf_valid_r <= up_valid;
        idx_r       <= '0;
      end else if (emit) begin
        idx_r <= idx_r + CNT_ONE;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      buf_r <= up_word;
    end
    if (emit) begin
      out_unit_r <= buf_r.units[idx_r];
      out_last_r <= buf_last;
    end
  end

endmodule

`default_nettype wire
